// ===== sv/bgcd_pkg.sv =====
// Package for the binary GCD unit: pipeline payload type and count width.
// No dependencies.
`timescale 1ns / 1ps

package bgcd_pkg;

	localparam int unsigned CountW = 6;

	// Pipeline payload: working pair, twos count and special-case flags
	typedef struct packed {
		logic [63:0]       a;
		logic [63:0]       b;
		logic [CountW-1:0] cnt;
		logic              zero_case;
		logic              undef;
	} gcd_state_t;

endpackage

// ===== sv/gcd_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface gcd_if #(parameter int unsigned PW = 64) (input logic clk);
	logic          valid;
	logic          ready;
	logic [PW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bgcd_stage.sv =====
// One pipeline stage of the binary GCD: STEPS reduction steps then a register.
// Depends on bgcd_pkg.
`timescale 1ns / 1ps

module bgcd_stage #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned STEPS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  bgcd_pkg::gcd_state_t    in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output bgcd_pkg::gcd_state_t    out_data
);
	import bgcd_pkg::*;

	gcd_state_t nxt;
	logic       valid_s1;
	gcd_state_t data_s1;

	// Chain of reduction steps; an equal pair is left as it is
	always_comb begin
		logic [WIDTH-1:0] a, b;
		logic [CountW-1:0] c;
		a = in_data.a[WIDTH-1:0];
		b = in_data.b[WIDTH-1:0];
		c = in_data.cnt;
		for (int i = 0; i < STEPS; i++) begin
			if (!in_data.zero_case && a != b) begin
				if (!a[0] && !b[0]) begin
					a = a >> 1;
					b = b >> 1;
					c = c + CountW'(1);
				end else if (!a[0]) begin
					a = a >> 1;
				end else if (!b[0]) begin
					b = b >> 1;
				end else if (a > b) begin
					a = (a - b) >> 1;
				end else begin
					b = (b - a) >> 1;
				end
			end
		end
		nxt = in_data;
		nxt.a = 64'(a);
		nxt.b = 64'(b);
		nxt.cnt = c;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	// Stage register with valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end
endmodule

// ===== sv/binary_gcd_unit.sv =====
// Binary GCD unit: a fully pipelined Stein reduction. A transaction enters
// every cycle unless the output stalls; the chain of at least 2*WIDTH
// reduction steps is split over NSTAGES register stages plus the output
// register. Backpressure stalls the occupied stages without loss.
`timescale 1ns / 1ps

module binary_gcd_unit #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned NSTAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	gcd_if.sink   in_ch,
	gcd_if.source out_ch
);
	import bgcd_pkg::*;

	localparam int unsigned Steps = (2 * WIDTH + NSTAGES - 1) / NSTAGES;

	logic [WIDTH-1:0] op_a, op_b;
	gcd_state_t       st [NSTAGES+1];
	logic             vld [NSTAGES+1];
	logic             rdy [NSTAGES+1];

	assign op_a = in_ch.data[WIDTH-1:0];
	assign op_b = in_ch.data[2*WIDTH-1:WIDTH];

	// Entry: zero operands bypass the reduction
	always_comb begin
		st[0] = '0;
		st[0].zero_case = (op_a == '0) || (op_b == '0);
		st[0].undef = (op_a == '0) && (op_b == '0);
		st[0].a = 64'(op_a | op_b);
		st[0].b = 64'(op_a | op_b);
		if (!st[0].zero_case) begin
			st[0].a = 64'(op_a);
			st[0].b = 64'(op_b);
		end
	end
	assign vld[0] = in_ch.valid;
	assign in_ch.ready = rdy[0];

	for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
		bgcd_stage #(.WIDTH(WIDTH), .STEPS(Steps)) u_stage (
			.clk(clk), .arst_n(arst_n),
			.in_valid(vld[g]), .in_ready(rdy[g]), .in_data(st[g]),
			.out_valid(vld[g+1]), .out_ready(rdy[g+1]), .out_data(st[g+1])
		);
	end

	// Output register: final shift by the twos count
	logic             valid_q;
	logic [WIDTH:0]   res_q;
	logic [WIDTH-1:0] fin;
	assign fin = st[NSTAGES].a[WIDTH-1:0] << st[NSTAGES].cnt;
	assign rdy[NSTAGES] = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy[NSTAGES]) begin
			valid_q <= vld[NSTAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NSTAGES] && vld[NSTAGES]) begin
			res_q <= {st[NSTAGES].undef, fin};
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.data  = res_q;

	// Output held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output changed under stall");
	// Undefined result carries zero divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data[WIDTH] |-> out_ch.data[WIDTH-1:0] == '0)
		else $error("undefined with nonzero divisor");
	// Fully reduced at the end of the pipe
	assert property (@(posedge clk) disable iff (!arst_n)
		vld[NSTAGES] |-> st[NSTAGES].a == st[NSTAGES].b)
		else $error("reduction incomplete");
endmodule
